[sv/assert_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define IMM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define IMM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/imm_pkg.sv]
package imm_pkg;

  localparam int MAX_DIM = 8;
  localparam int DIM_W   = $clog2(MAX_DIM);
  localparam int ADDR_W  = 2 * DIM_W;
  localparam int DEPTH   = MAX_DIM * MAX_DIM;
  localparam int DATA_W  = 32;
  localparam int CFG_W   = 4;
  localparam int CMD_W   = 2;
  localparam int REG_W   = 2;

  // input command codes
  localparam logic [CMD_W-1:0] CMD_LOAD_A  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_LOAD_B  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

  // configuration register indexes
  localparam logic [REG_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [REG_W-1:0] REG_INNER_DIM = 2'd1;
  localparam logic [REG_W-1:0] REG_COLS_B    = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(MAX_DIM);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_EMIT
  } imm_state_t;

  typedef struct packed {
    logic             wr_a;
    logic             wr_b;
    logic             mac_issue;
    logic             acc_clear;
    logic             emit;
    logic             emit_last;
    logic [DIM_W-1:0] idx_i;
    logic [DIM_W-1:0] idx_j;
    logic [DIM_W-1:0] idx_k;
  } imm_cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic out_free;
  } imm_status_t;

  // Last index for a dimension register: zero acts as one, saturate at MAX_DIM.
  function automatic logic [DIM_W-1:0] eff_last(input logic [CFG_W-1:0] v);
    logic [CFG_W-1:0] m1;
    begin
      m1 = v - CFG_W'(1);
      if (v == '0) begin
        return '0;
      end else if (v > CFG_W'(MAX_DIM)) begin
        return DIM_W'(MAX_DIM - 1);
      end else begin
        return m1[DIM_W-1:0];
      end
    end
  endfunction

endpackage

[sv/imm_ctrl.sv]
`include "assert_macros.svh"

module imm_ctrl import imm_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CMD_W-1:0]   in_cmd,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [REG_W-1:0]   cfg_index,
  input  logic [CFG_W-1:0]   cfg_data,
  input  imm_status_t        status,
  output imm_cmd_t           cmd
);

  imm_state_t       state, state_next;
  logic [CFG_W-1:0] rows_a, inner_dim, cols_b;
  logic [DIM_W-1:0] i, j, k;
  logic [DIM_W-1:0] m_last, n_last, p_last;
  logic             in_fire, k_done, elem_last;

  assign m_last    = eff_last(rows_a);
  assign n_last    = eff_last(inner_dim);
  assign p_last    = eff_last(cols_b);
  assign cfg_ready = 1'b1;
  assign in_fire   = in_valid && in_ready;
  assign k_done    = (k == n_last);
  assign elem_last = (i == m_last) && (j == p_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROWS_A:    rows_a    <= cfg_data;
        REG_INNER_DIM: inner_dim <= cfg_data;
        REG_COLS_B:    cols_b    <= cfg_data;
        default:       ;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_fire && in_cmd == CMD_COMPUTE) state_next = ST_RUN;
      end
      ST_RUN: begin
        if (k_done) state_next = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (status.out_free) state_next = elem_last ? ST_IDLE : ST_RUN;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = 1'b0;
    cmd           = '0;
    cmd.idx_i     = i;
    cmd.idx_j     = j;
    cmd.idx_k     = k;
    cmd.emit_last = elem_last;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.wr_a = in_fire && in_cmd == CMD_LOAD_A;
        cmd.wr_b = in_fire && in_cmd == CMD_LOAD_B;
      end
      ST_RUN: begin
        cmd.mac_issue = 1'b1;
        cmd.acc_clear = (k == '0);
      end
      ST_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE) begin
        i <= '0;
        j <= '0;
        k <= '0;
      end else if (state == ST_RUN) begin
        k <= k_done ? '0 : k + DIM_W'(1);
      end else if (cmd.emit) begin
        // advance to the next element, row-major
        if (j == p_last) begin
          j <= '0;
          i <= i + DIM_W'(1);
        end else begin
          j <= j + DIM_W'(1);
        end
      end
    end
  end

  `IMM_ASSERT(a_ready_pipe_idle, in_ready |-> !status.pipe_busy, "word taken while MAC pipe busy")
  `IMM_ASSERT(a_emit_drained, cmd.emit |-> !status.pipe_busy, "result emitted before drain")
  `IMM_ASSERT(a_last_to_idle, (cmd.emit && cmd.emit_last) |=> state == ST_IDLE, "no idle after last")

endmodule

[sv/imm_dp.sv]
`include "assert_macros.svh"

module imm_dp import imm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  imm_cmd_t          cmd,
  output imm_status_t       status,
  input  logic [DIM_W-1:0]  ld_row,
  input  logic [DIM_W-1:0]  ld_col,
  input  logic [DATA_W-1:0] ld_value,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [DIM_W-1:0]  out_row,
  output logic [DIM_W-1:0]  out_col,
  output logic [DATA_W-1:0] out_value,
  output logic              out_last
);

  logic [DATA_W-1:0]   store_a [DEPTH];
  logic [DATA_W-1:0]   store_b [DEPTH];
  logic [DATA_W-1:0]   rd_a, rd_b, prod, acc;
  logic [DATA_W-1:0]   full_prod;
  logic                v1, v2;

  always_ff @(posedge clk) begin
    if (cmd.wr_a) store_a[{ld_row, ld_col}] <= ld_value;
    if (cmd.wr_b) store_b[{ld_row, ld_col}] <= ld_value;
    if (cmd.mac_issue) begin
      rd_a <= store_a[{cmd.idx_i, cmd.idx_k}];
      rd_b <= store_b[{cmd.idx_k, cmd.idx_j}];
    end
  end

  // low word of the product is the same for signed and unsigned operands
  assign full_prod = rd_a * rd_b;

  always_ff @(posedge clk) begin
    if (v1) prod <= full_prod[DATA_W-1:0];
    if (cmd.acc_clear) begin
      acc <= '0;
    end else if (v2) begin
      acc <= acc + prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= cmd.mac_issue;
      v2 <= v1;
    end
  end

  assign status.pipe_busy = v1 || v2;
  assign status.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_row   <= cmd.idx_i;
      out_col   <= cmd.idx_j;
      out_value <= acc;
      out_last  <= cmd.emit_last;
    end
  end

  `IMM_ASSERT(a_no_overwrite, cmd.emit |-> (!out_valid || out_ready), "output word overwritten")
  `IMM_ASSERT(a_stage_order, v2 |-> $past(v1), "accumulate without product")
  `IMM_ASSERT_ALWAYS(a_rst_pipe, $past(rst) |-> (!v1 && !v2 && !out_valid), "state after reset")

endmodule

[sv/integer_matrix_multiply_unit.sv]
// Signed 32-bit integer matrix multiplier, C = A * B, up to 8x8 by 8x8.
// Input stream (s_axis): tuser carries the command (load A element, load B
// element, compute); tdata carries row, column and element value. A load word
// is written into the A or B store in the cycle it is taken and gives no
// output. A compute word emits rows_a * cols_b words of C on m_axis in
// row-major order, tlast set on the final one. Sums wrap modulo 2^32.
// Configuration (cfg_*): index 0 rows_a, 1 inner_dim, 2 cols_b; write only
// while no product is in flight. Zero acts as 1, values above 8 as 8.
// Each C element is computed in steps: one store read per inner_dim step
// into the single multiply-accumulate unit, a drain of the pipeline, and a
// hand-off to the output register. s_axis_tready stays low until the last
// element sits in the output register. When the receiver stalls, the output
// register holds its word and the next element, once computed, waits in the
// hand-off step until the register is free. Reset clears control state and
// sets all three dimensions to 8; the stores are undefined until written.
module integer_matrix_multiply_unit import imm_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [39:0]          s_axis_tdata,  // row_index[2:0], col_index[5:3], elem_value[37:6]
  input  logic [CMD_W-1:0]     s_axis_tuser,  // command[1:0]
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [39:0]          m_axis_tdata,  // out_row[2:0], out_col[5:3], prod_value[37:6]
  output logic                 m_axis_tlast,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_W-1:0]     cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  imm_cmd_t          cmd;
  imm_status_t       status;
  logic [DIM_W-1:0]  out_row, out_col;
  logic [DATA_W-1:0] out_value;

  imm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_cmd    (s_axis_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .status    (status),
    .cmd       (cmd)
  );

  imm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .ld_row    (s_axis_tdata[2:0]),
    .ld_col    (s_axis_tdata[5:3]),
    .ld_value  (s_axis_tdata[37:6]),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_row   (out_row),
    .out_col   (out_col),
    .out_value (out_value),
    .out_last  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_value, out_col, out_row};

endmodule

[tb/integer_matrix_multiply_unit_test.sv]
module integer_matrix_multiply_unit_test;
  import imm_pkg::*;

  localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;
  localparam logic [REG_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 32;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_WORDS = 176;
  localparam int SCRIPT_LEN   = 21;

  typedef struct packed {
    logic [2:0]  row;
    logic [2:0]  col;
    logic [31:0] value;
    logic        last;
  } c_elem_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic [2:0]       row;
    logic [2:0]       col;
    logic [31:0]      value;
    logic             typed;
    logic [31:0]      result;
  } script_row_t;

  // 1x1x1 product: compute rows carry the single C element they must give
  localparam script_row_t SCRIPT [0:SCRIPT_LEN-1] = '{
    '{CMD_LOAD_A,  3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{CMD_LOAD_B,  3'd0, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0000_0001},
    '{CMD_LOAD_A,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd7, 3'd7, 32'hFFFF_FFFF, 1'b1, 32'h8000_0000},
    '{CMD_LOAD_B,  3'd0, 3'd0, 32'h8000_0000, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0000_0000},
    '{CMD_LOAD_A,  3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000},
    '{CMD_SPARE,   3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{CMD_LOAD_B,  3'd7, 3'd7, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{CMD_LOAD_A,  3'd7, 3'd0, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{CMD_LOAD_B,  3'd0, 3'd7, 32'h7FFF_FFFF, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h8000_0000},
    '{CMD_LOAD_B,  3'd0, 3'd0, 32'hFFFF_FFFF, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0000_0001},
    '{CMD_LOAD_A,  3'd0, 3'd0, 32'h0000_0000, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'h0000_0000},
    '{CMD_LOAD_A,  3'd0, 3'd0, 32'h0000_0003, 1'b0, 32'h0},
    '{CMD_LOAD_B,  3'd0, 3'd0, 32'hFFFF_FFFE, 1'b0, 32'h0},
    '{CMD_COMPUTE, 3'd0, 3'd0, 32'h0,         1'b1, 32'hFFFF_FFFA}
  };

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [39:0]      s_axis_tdata = '0;   // row_index[2:0], col_index[5:3], elem_value[37:6]
  logic [CMD_W-1:0] s_axis_tuser = CMD_LOAD_A;  // command[1:0]
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [39:0]      m_axis_tdata;        // out_row[2:0], out_col[5:3], prod_value[37:6]
  logic             m_axis_tlast;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [REG_W-1:0] cfg_index = REG_ROWS_A;
  logic [CFG_W-1:0] cfg_data = '0;

  integer_matrix_multiply_unit dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [31:0]      mat_a [0:DEPTH-1];
  logic [31:0]      mat_b [0:DEPTH-1];
  bit               a_set [0:DEPTH-1];
  bit               b_set [0:DEPTH-1];
  logic [CFG_W-1:0] rows_raw  = DIM_RESET;
  logic [CFG_W-1:0] inner_raw = DIM_RESET;
  logic [CFG_W-1:0] cols_raw  = DIM_RESET;
  c_elem_t          c_pending [$];

  int          errors = 0;
  int          words_sent = 0;
  int          burst_left = 0;
  bit          gapless = 1'b0;
  int unsigned cyc = 0;
  int          quiet_cycles = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic int dim_span(input logic [CFG_W-1:0] v);
    if (v == '0) return 1;
    if (v > CFG_W'(MAX_DIM)) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic logic [31:0] pick_elem();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'hFFFF_FFFF - 32'($urandom_range(0, 15));
      3: return 32'($urandom_range(0, 15));
      default: return $urandom();
    endcase
  endfunction

  task automatic predict_product();
    int m, n, p;
    logic [31:0] acc;
    m = dim_span(rows_raw);
    n = dim_span(inner_raw);
    p = dim_span(cols_raw);
    for (int i = 0; i < m; i++) begin
      for (int j = 0; j < p; j++) begin
        acc = '0;
        for (int k = 0; k < n; k++) begin
          acc = acc + mat_a[i * MAX_DIM + k] * mat_b[k * MAX_DIM + j];
        end
        c_pending.push_back('{3'(i), 3'(j), acc, (i == m - 1) && (j == p - 1)});
      end
    end
  endtask

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [2:0] r,
                           input logic [2:0] c, input logic [31:0] v,
                           input bit typed, input logic [31:0] typed_val);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = gapless ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= cmd;
    s_axis_tdata  <= {2'b00, v, c, r};
    do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    case (cmd)
      CMD_LOAD_A: begin
        mat_a[{r, c}] = v;
        a_set[{r, c}] = 1'b1;
      end
      CMD_LOAD_B: begin
        mat_b[{r, c}] = v;
        b_set[{r, c}] = 1'b1;
      end
      CMD_COMPUTE: begin
        if (typed) c_pending.push_back('{3'd0, 3'd0, typed_val, 1'b1});
        else predict_product();
      end
      default: ;
    endcase
    if (cmd != CMD_SPARE) words_sent++;
  endtask

  // load every operand the next product reads that has never been written
  task automatic fill_operands();
    int m, n, p;
    m = dim_span(rows_raw);
    n = dim_span(inner_raw);
    p = dim_span(cols_raw);
    for (int i = 0; i < m; i++)
      for (int k = 0; k < n; k++)
        if (!a_set[i * MAX_DIM + k]) send_word(CMD_LOAD_A, 3'(i), 3'(k), pick_elem(), 0, '0);
    for (int k = 0; k < n; k++)
      for (int j = 0; j < p; j++)
        if (!b_set[k * MAX_DIM + j]) send_word(CMD_LOAD_B, 3'(k), 3'(j), pick_elem(), 0, '0);
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    while (c_pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // write the three dimensions in random order, sometimes with the unused index too
  task automatic cfg_apply(input logic [CFG_W-1:0] m, input logic [CFG_W-1:0] n,
                           input logic [CFG_W-1:0] p, input bit spare);
    logic [REG_W-1:0] idx [0:3];
    logic [CFG_W-1:0] dat [0:3];
    logic [REG_W-1:0] ti;
    logic [CFG_W-1:0] td;
    int cnt, s;
    idx[0] = REG_ROWS_A;    dat[0] = m;
    idx[1] = REG_INNER_DIM; dat[1] = n;
    idx[2] = REG_COLS_B;    dat[2] = p;
    idx[3] = REG_SPARE;     dat[3] = CFG_W'($urandom_range(0, 15));
    cnt = spare ? 4 : 3;
    for (int i = cnt - 1; i > 0; i--) begin
      s = $urandom_range(0, i);
      ti = idx[i]; idx[i] = idx[s]; idx[s] = ti;
      td = dat[i]; dat[i] = dat[s]; dat[s] = td;
    end
    for (int i = 0; i < cnt; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= dat[i];
      do @(posedge clk); while (!(cfg_valid && cfg_ready));
      case (idx[i])
        REG_ROWS_A:    rows_raw  = dat[i];
        REG_INNER_DIM: inner_raw = dat[i];
        REG_COLS_B:    cols_raw  = dat[i];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(input int budget);
    int stop_at, m, n, p, loads;
    bit side_a, near;
    logic [2:0] r, c;
    stop_at = words_sent + budget;
    gapless = ($urandom_range(0, 3) == 0);
    m = dim_span(rows_raw);
    n = dim_span(inner_raw);
    p = dim_span(cols_raw);
    while (words_sent < stop_at) begin
      if ($urandom_range(0, 9) < 8) begin
        loads = $urandom_range(0, 6);
        repeat (loads) begin
          side_a = $urandom_range(0, 1);
          near = ($urandom_range(0, 4) != 0);
          if (side_a) begin
            r = near ? 3'($urandom_range(0, m - 1)) : 3'($urandom_range(0, 7));
            c = near ? 3'($urandom_range(0, n - 1)) : 3'($urandom_range(0, 7));
            send_word(CMD_LOAD_A, r, c, pick_elem(), 0, '0);
          end else begin
            r = near ? 3'($urandom_range(0, n - 1)) : 3'($urandom_range(0, 7));
            c = near ? 3'($urandom_range(0, p - 1)) : 3'($urandom_range(0, 7));
            send_word(CMD_LOAD_B, r, c, pick_elem(), 0, '0);
          end
        end
        fill_operands();
        send_word(CMD_COMPUTE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  $urandom(), 0, '0);
      end else if ($urandom_range(0, 1) == 0) begin
        send_word(CMD_SPARE, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                  $urandom(), 0, '0);
      end else begin
        send_word($urandom_range(0, 1) ? CMD_LOAD_A : CMD_LOAD_B,
                  3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), pick_elem(), 0, '0);
      end
    end
  endtask

  initial begin
    logic [CFG_W-1:0] dims [0:5][0:2];
    int budget;
    dims = '{'{4'd8, 4'd8, 4'd8}, '{4'd0, 4'd15, 4'd3}, '{4'd15, 4'd0, 4'd8},
             '{4'd3, 4'd7, 4'd2}, '{4'd2, 4'd1, 4'd5}, '{4'd9, 4'd4, 4'd6}};
    budget = RANDOM_WORDS / 8;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    cfg_apply(4'd1, 4'd1, 4'd1, 1'b1);
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_word(SCRIPT[i].cmd, SCRIPT[i].row, SCRIPT[i].col, SCRIPT[i].value,
                SCRIPT[i].typed, SCRIPT[i].result);
    end
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      if (ph < 6) cfg_apply(dims[ph][0], dims[ph][1], dims[ph][2], ph == 3);
      else cfg_apply(CFG_W'($urandom_range(0, 15)), CFG_W'($urandom_range(0, 15)),
                     CFG_W'($urandom_range(0, 15)), 1'b0);
      run_phase(budget);
    end
    settle();
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver back-pressure: free run, light random, periodic, heavy random
  always @(posedge clk) begin
    cyc <= cyc + 1;
    case (cyc[8:7])
      2'd0: m_axis_tready <= 1'b1;
      2'd1: m_axis_tready <= ($urandom_range(0, 2) != 0);
      2'd2: m_axis_tready <= ((cyc % 7) > 2);
      default: m_axis_tready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  always @(posedge clk) begin
    c_elem_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (c_pending.size() == 0) begin
        $error("C word with nothing pending: tdata %h tlast %b", m_axis_tdata, m_axis_tlast);
        errors++;
      end else begin
        want = c_pending.pop_front();
        if (m_axis_tdata[2:0] !== want.row) begin
          $error("out_row expected %0d actual %0d", want.row, m_axis_tdata[2:0]);
          errors++;
        end
        if (m_axis_tdata[5:3] !== want.col) begin
          $error("out_col expected %0d actual %0d", want.col, m_axis_tdata[5:3]);
          errors++;
        end
        if (m_axis_tdata[37:6] !== want.value) begin
          $error("prod_value expected %h actual %h", want.value, m_axis_tdata[37:6]);
          errors++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last expected %b actual %b", want.last, m_axis_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
